/* design/blis_pkg.sv */
// Package: shared types, codes and field widths for the bounded integer list.
`timescale 1ns / 1ps
`default_nettype none
package blis_pkg;

  localparam int OP_W      = 3;
  localparam int VALUE_W   = 32;
  localparam int INDEX_W   = 6;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 6;
  localparam int COUNT_W   = 7;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_READ   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_POP    = 3'd3,
    OP_SORT   = 3'd4
  } blis_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } blis_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SHIFT,
    S_SORT,
    S_SORT_END,
    S_DONE
  } blis_state_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_INDEX,
    RD_TAIL,
    RD_PTR
  } blis_rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_APPEND,
    WR_SHIFT,
    WR_SORT,
    WR_CARRY
  } blis_wr_sel_t;

  typedef struct packed {
    logic         capture;
    logic         set_res;
    blis_status_t status;
    logic         pos_count;
    logic         count_inc;
    logic         count_dec;
    blis_rd_sel_t rd;
    blis_wr_sel_t wr;
    logic         ptr_index;
    logic         ptr_zero;
    logic         ptr_inc;
    logic         take_read;
    logic         out_load;
  } blis_cmd_t;

  typedef struct packed {
    blis_op_t op;
    logic     idx_in_range;
    logic     empty;
    logic     full;
    logic     multi;
    logic     ptr_lt_count;
    logic     rd_valid;
    logic     swapped;
    logic     out_free;
  } blis_stat_t;

endpackage
`default_nettype wire

/* design/blis_ctrl.sv */
// Controller: state machine that sequences each request over the datapath.
`timescale 1ns / 1ps
`default_nettype none
module blis_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire blis_pkg::blis_stat_t stat,
  output blis_pkg::blis_cmd_t      cmd
);
  import blis_pkg::*;

  blis_state_t state;
  blis_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_res = 1'b1;
        cmd.status  = ST_OK;
        state_next  = S_DONE;
        unique case (stat.op)
          OP_APPEND: begin
            if (stat.full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.wr        = WR_APPEND;
              cmd.pos_count = 1'b1;
              cmd.count_inc = 1'b1;
            end
          end
          OP_READ: begin
            if (!stat.idx_in_range) begin
              cmd.status = ST_RANGE;
            end else begin
              cmd.rd     = RD_INDEX;
              state_next = S_READ;
            end
          end
          OP_REMOVE: begin
            if (!stat.idx_in_range) begin
              cmd.status = ST_RANGE;
            end else begin
              cmd.ptr_index = 1'b1;
              state_next    = S_SHIFT;
            end
          end
          OP_POP: begin
            if (stat.empty) begin
              cmd.status = ST_EMPTY;
            end else begin
              cmd.rd        = RD_TAIL;
              cmd.count_dec = 1'b1;
              state_next    = S_READ;
            end
          end
          OP_SORT: begin
            if (stat.multi) begin
              cmd.ptr_zero = 1'b1;
              state_next   = S_SORT;
            end
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        cmd.take_read = 1'b1;
        state_next    = S_DONE;
      end
      S_SHIFT: begin
        if (stat.ptr_lt_count) begin
          cmd.rd      = RD_PTR;
          cmd.ptr_inc = 1'b1;
        end
        if (stat.rd_valid) begin
          cmd.wr = WR_SHIFT;
        end
        if (!stat.ptr_lt_count && !stat.rd_valid) begin
          cmd.count_dec = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_SORT: begin
        if (stat.ptr_lt_count) begin
          cmd.rd      = RD_PTR;
          cmd.ptr_inc = 1'b1;
        end
        if (stat.rd_valid) begin
          cmd.wr = WR_SORT;
        end
        if (!stat.ptr_lt_count && !stat.rd_valid) begin
          state_next = S_SORT_END;
        end
      end
      S_SORT_END: begin
        cmd.wr = WR_CARRY;
        if (stat.swapped) begin
          cmd.ptr_zero = 1'b1;
          state_next   = S_SORT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/blis_datapath.sv */
// Datapath: entry memory, count, scan pointer, sort carry and output register.
`timescale 1ns / 1ps
`default_nettype none
module blis_datapath #(
  parameter int CAPACITY = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire blis_pkg::blis_cmd_t                 cmd,
  output blis_pkg::blis_stat_t                     stat,
  input  wire logic [blis_pkg::OP_W-1:0]           in_operation,
  input  wire logic signed [blis_pkg::VALUE_W-1:0] in_value,
  input  wire logic [blis_pkg::INDEX_W-1:0]        in_index,
  input  wire logic                                in_descending,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [blis_pkg::STATUS_W-1:0]            out_status,
  output logic signed [blis_pkg::VALUE_W-1:0]      out_read_value,
  output logic [blis_pkg::POS_W-1:0]               out_position,
  output logic [blis_pkg::COUNT_W-1:0]             out_count
);
  import blis_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int XW   = (CW > COUNT_W) ? CW : COUNT_W;

  logic signed [VALUE_W-1:0] mem [CAPACITY];

  blis_op_t                  op;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;
  logic                      descending;

  logic [CW-1:0]             count;
  logic [CW-1:0]             ptr;
  logic                      swapped;
  logic signed [VALUE_W-1:0] carry;

  logic signed [VALUE_W-1:0] rdata;
  logic [AW-1:0]             raddr_q;
  logic                      rd_valid;

  blis_status_t              res_status;
  logic signed [VALUE_W-1:0] res_value;
  logic [POS_W-1:0]          res_pos;

  logic [CMPW-1:0]           idx_x;
  logic [CMPW-1:0]           idx_p1;
  logic [CMPW-1:0]           cnt_c;
  logic [XW-1:0]             count_x;
  logic [CW-1:0]             count_m1;
  logic [AW-1:0]             raddr;
  logic [AW-1:0]             raddr_q_m1;
  logic                      out_of_order;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic signed [VALUE_W-1:0] wdata;

  assign idx_x      = CMPW'(index);
  assign idx_p1     = idx_x + CMPW'(1);
  assign cnt_c      = CMPW'(count);
  assign count_x    = XW'(count);
  assign count_m1   = count - CW'(1);
  assign raddr_q_m1 = raddr_q - AW'(1);
  assign out_of_order = descending ? (rdata > carry) : (carry > rdata);

  assign stat.op           = op;
  assign stat.idx_in_range = idx_x < cnt_c;
  assign stat.empty        = (count == '0);
  assign stat.full         = (count == CW'(CAPACITY));
  assign stat.multi        = (count >= CW'(2));
  assign stat.ptr_lt_count = (ptr < count);
  assign stat.rd_valid     = rd_valid;
  assign stat.swapped      = swapped;
  assign stat.out_free     = !out_valid || out_ready;

  always_comb begin
    unique case (cmd.rd)
      RD_INDEX: raddr = idx_x[AW-1:0];
      RD_TAIL:  raddr = count_m1[AW-1:0];
      RD_PTR:   raddr = ptr[AW-1:0];
      default:  raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = raddr_q_m1;
    wdata = rdata;
    unique case (cmd.wr)
      WR_APPEND: begin
        we    = 1'b1;
        waddr = count[AW-1:0];
        wdata = value;
      end
      WR_SHIFT: begin
        we = 1'b1;
      end
      WR_SORT: begin
        we    = (raddr_q != '0);
        wdata = out_of_order ? rdata : carry;
      end
      WR_CARRY: begin
        we    = 1'b1;
        waddr = count_m1[AW-1:0];
        wdata = carry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd != RD_NONE) begin
      rdata <= mem[raddr];
    end
    raddr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op         <= blis_op_t'(in_operation);
      value      <= in_value;
      index      <= in_index;
      descending <= in_descending;
    end
    if (cmd.set_res) begin
      res_status <= cmd.status;
      res_value  <= '0;
      res_pos    <= cmd.pos_count ? count_x[POS_W-1:0] : '0;
    end
    if (cmd.take_read) begin
      res_value <= rdata;
    end
    if (cmd.wr == WR_SORT && (raddr_q == '0 || !out_of_order)) begin
      carry <= rdata;
    end
    if (cmd.out_load) begin
      out_status     <= res_status;
      out_read_value <= res_value;
      out_position   <= res_pos;
      out_count      <= count_x[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      swapped   <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= (cmd.rd != RD_NONE);
      if (cmd.count_inc) begin
        count <= count + CW'(1);
      end else if (cmd.count_dec) begin
        count <= count_m1;
      end
      if (cmd.ptr_index) begin
        ptr <= idx_p1[CW-1:0];
      end else if (cmd.ptr_zero) begin
        ptr <= '0;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + CW'(1);
      end
      if (cmd.ptr_zero) begin
        swapped <= 1'b0;
      end else if (cmd.wr == WR_SORT && raddr_q != '0 && out_of_order) begin
        swapped <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* design/bounded_int_list_with_sort.sv */
// Top level: bounded list of signed 32-bit values with append, read, remove, pop and sort.
//
// Requests enter on the s_ group and one response per request leaves on the m_ group;
// both use the tvalid/tready handshake.  s_tuser carries the operation code, s_tdata the
// value, index and sort order.  m_tuser carries the status, m_tdata the value read, the
// append position and the entry count after the request.
// One request is processed at a time; s_tready is high only while the block is idle.
// Steps from acceptance to m_tvalid (n = entries held, i = index):
//   append, pop error, read error, remove error, unused codes, short sort: execute, done
//   read and pop: execute, read (registered memory read), done
//   remove: entries i + 1 to n - 1 shift down, one entry moved per cycle through the memory port pair
//   sort: bubble passes over the one read / one write memory port, repeated until a pass
//   makes no exchange.
// The next request can be accepted in the same cycle that m_tvalid rises.
// The response waits in an output register, so a new request is accepted while the
// previous response is still stalled; a finished request waits in its last state until
// that register is free.  Reset empties the list and drops any pending response; the
// entry memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bounded_int_list_with_sort #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // value[31:0], index[37:32], descending[38], zero
  input  wire logic [2:0]  s_tuser,  // operation[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // read_value[31:0], position[37:32], count[44:38], zero
  output logic [1:0]       m_tuser   // status[1:0]
);
  import blis_pkg::*;

  blis_cmd_t                 cmd;
  blis_stat_t                stat;
  logic [STATUS_W-1:0]       out_status;
  logic signed [VALUE_W-1:0] out_read_value;
  logic [POS_W-1:0]          out_position;
  logic [COUNT_W-1:0]        out_count;

  blis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  blis_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_operation   (s_tuser[OP_W-1:0]),
    .in_value       (s_tdata[31:0]),
    .in_index       (s_tdata[37:32]),
    .in_descending  (s_tdata[38]),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_position   (out_position),
    .out_count      (out_count)
  );

  assign m_tuser = out_status;
  assign m_tdata = {3'b000, out_count, out_position, out_read_value};

endmodule
`default_nettype wire
